### hw/rtl/assert_macros.svh
// assertion macros shared by the encoder rtl
// no dependencies; bodies compile away when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion violated");
// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion violated");
// condition never holds
`define ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("assertion violated");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`define ASSERT_NEVER(label, clk, rst, cond)
`endif
`endif

### hw/rtl/lz78be_pkg.sv
// types and constants of the bitwise lz78 encoder
// no dependencies; used by the byte and code interfaces, controller, datapath and top level
package lz78be_pkg;

  // fixed field widths
  localparam int unsigned DATA_BYTE_W       = 8;
  localparam int unsigned CODE_PREFIX_W     = 15;
  localparam int unsigned NARROW_INDEX_BITS = 7;
  localparam int unsigned BIT_CNT_W         = 3;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BIT,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_MISS,
    ST_TAIL,
    ST_FLUSH,
    ST_DONE
  } ctrl_state_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;        // latch a new byte
    logic bit_setup;   // form the code of the current bit, set scan start
    logic scan_rd;     // read dictionary at scan index
    logic scan_cmp;    // compare read entry with the code
    logic miss_take;   // store and queue the code of a miss
    logic flush_rd;    // read dictionary at the prefix
    logic flush_take;  // queue the flushed pair
    logic finish;      // release the final code, restart on last byte
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic scan_empty;  // nothing to search for this bit
    logic hit;         // read entry equals the code
    logic scan_end;    // next scan index reaches the entry count
    logic can_emit;    // pending code can move to the output register
    logic bit_last;    // working on bit seven
    logic last_flag;   // byte marks end of stream
    logic prefix_nz;   // prefix is not empty
    logic pend_valid;  // a code waits in the pending register
  } status_t;

endpackage

### hw/rtl/lz78be_byte_if.sv
// input byte channel: valid/ready plus payload
// depends on lz78be_pkg
interface lz78be_byte_if;
  logic                                  valid;
  logic                                  ready;
  logic [lz78be_pkg::DATA_BYTE_W-1:0]    data_byte;
  logic                                  last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

### hw/rtl/lz78be_code_if.sv
// output code channel: valid/ready plus payload
// depends on lz78be_pkg
interface lz78be_code_if;
  logic                                  valid;
  logic                                  ready;
  logic [lz78be_pkg::CODE_PREFIX_W-1:0]  code_prefix;
  logic                                  code_bit;
  logic                                  run_last;
  logic                                  stream_end;

  modport source (
    output valid, output code_prefix, output code_bit, output run_last,
    output stream_end, input ready
  );
  modport sink (
    input valid, input code_prefix, input code_bit, input run_last,
    input stream_end, output ready
  );
endinterface

### hw/rtl/lz78be_cfg_if.sv
// configuration write channel for the code width register
// no dependencies
interface lz78be_cfg_if;
  logic valid;
  logic ready;
  logic wide_codes;

  modport source (output valid, output wide_codes, input ready);
  modport sink (input valid, input wide_codes, output ready);
endinterface

### hw/rtl/lz78_bitwise_encoder_unit.sv
// Per byte: a load, then per bit a setup, a read and a compare for each dictionary entry
// scanned and a store on a miss, plus a flush read on the last byte if the prefix is nonempty, and a final release.
// Throughput: one byte at a time; the rate is set by the linear walk over the
// dictionary memory, each compare waiting on a registered read.
// Reset clears the entry count to 1, the prefix to 0 and the code width to wide;
// dictionary contents are not cleared, only entries below the count are read.
module lz78_bitwise_encoder_unit #(
  parameter int unsigned MAX_INDEX_BITS = 15
) (
  input  logic                 clk,
  input  logic                 rst,
  lz78be_byte_if.sink          byte_in,
  lz78be_code_if.source        code_out,
  lz78be_cfg_if.sink           cfg
);

  lz78be_pkg::cmd_t    cmd;
  lz78be_pkg::status_t status;
  logic                in_ready;

  // configuration is taken whenever the block is out of reset
  assign cfg.ready     = !rst;
  assign byte_in.ready = in_ready && !rst;

  // controller
  lz78be_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (byte_in.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath
  lz78be_dpath #(
    .MAX_INDEX_BITS (MAX_INDEX_BITS)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg_we      (cfg.valid),
    .cfg_wide    (cfg.wide_codes),
    .data_byte   (byte_in.data_byte),
    .last_byte   (byte_in.last_byte),
    .code_valid  (code_out.valid),
    .code_ready  (code_out.ready),
    .code_prefix (code_out.code_prefix),
    .code_bit    (code_out.code_bit),
    .run_last    (code_out.run_last),
    .stream_end  (code_out.stream_end)
  );

endmodule

### hw/rtl/lz78be_ctrl.sv
// controller state machine of the encoder: sequences bit scans and code release
// depends on lz78be_pkg and assert_macros.svh
`include "assert_macros.svh"

module lz78be_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  lz78be_pkg::status_t  status,
  output lz78be_pkg::cmd_t     cmd
);

  lz78be_pkg::ctrl_state_t state;
  lz78be_pkg::ctrl_state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lz78be_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      lz78be_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = lz78be_pkg::ST_BIT;
        end
      end
      lz78be_pkg::ST_BIT: begin
        cmd.bit_setup = 1'b1;
        state_next    = status.scan_empty ? lz78be_pkg::ST_MISS : lz78be_pkg::ST_SCAN_RD;
      end
      lz78be_pkg::ST_SCAN_RD: begin
        cmd.scan_rd = 1'b1;
        state_next  = lz78be_pkg::ST_SCAN_CMP;
      end
      lz78be_pkg::ST_SCAN_CMP: begin
        cmd.scan_cmp = 1'b1;
        if (status.hit) begin
          state_next = status.bit_last ? lz78be_pkg::ST_TAIL : lz78be_pkg::ST_BIT;
        end else if (status.scan_end) begin
          state_next = lz78be_pkg::ST_MISS;
        end else begin
          state_next = lz78be_pkg::ST_SCAN_RD;
        end
      end
      lz78be_pkg::ST_MISS: begin
        if (status.can_emit) begin
          cmd.miss_take = 1'b1;
          state_next    = status.bit_last ? lz78be_pkg::ST_TAIL : lz78be_pkg::ST_BIT;
        end
      end
      lz78be_pkg::ST_TAIL: begin
        if (status.last_flag && status.prefix_nz) begin
          cmd.flush_rd = 1'b1;
          state_next   = lz78be_pkg::ST_FLUSH;
        end else begin
          state_next = lz78be_pkg::ST_DONE;
        end
      end
      lz78be_pkg::ST_FLUSH: begin
        if (status.can_emit) begin
          cmd.flush_take = 1'b1;
          state_next     = lz78be_pkg::ST_DONE;
        end
      end
      lz78be_pkg::ST_DONE: begin
        if (status.can_emit) begin
          cmd.finish = 1'b1;
          state_next = lz78be_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lz78be_pkg::ST_IDLE;
      end
    endcase
  end

  // a new byte never starts while a code of the previous one is held back
  `ASSERT_IMPLIES(idle_no_pending, clk, rst, state == lz78be_pkg::ST_IDLE, !status.pend_valid)
  // a flush read is only issued for a nonempty prefix on the last byte
  `ASSERT_IMPLIES(flush_only_last, clk, rst, cmd.flush_rd, status.last_flag && status.prefix_nz)

endmodule

### hw/rtl/lz78be_dpath.sv
// datapath of the encoder: dictionary memory, prefix, count, pending and output codes
// depends on lz78be_pkg and assert_macros.svh
`include "assert_macros.svh"

module lz78be_dpath #(
  parameter int unsigned MAX_INDEX_BITS = 15
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  lz78be_pkg::cmd_t                       cmd,
  output lz78be_pkg::status_t                    status,
  input  logic                                   cfg_we,
  input  logic                                   cfg_wide,
  input  logic [lz78be_pkg::DATA_BYTE_W-1:0]     data_byte,
  input  logic                                   last_byte,
  output logic                                   code_valid,
  input  logic                                   code_ready,
  output logic [lz78be_pkg::CODE_PREFIX_W-1:0]   code_prefix,
  output logic                                   code_bit,
  output logic                                   run_last,
  output logic                                   stream_end
);

  localparam int unsigned IW    = MAX_INDEX_BITS;
  localparam int unsigned CW    = MAX_INDEX_BITS + 1;
  localparam int unsigned DEPTH = 1 << MAX_INDEX_BITS;
  localparam logic [CW-1:0] NarrowMask  = CW'((1 << (lz78be_pkg::NARROW_INDEX_BITS + 1)) - 1);
  localparam logic [CW-1:0] NarrowLimit = CW'(1 << lz78be_pkg::NARROW_INDEX_BITS);
  localparam logic [CW-1:0] WideLimit   = CW'(DEPTH);

  // dictionary memory
  logic [CW-1:0] mem [DEPTH];
  logic [CW-1:0] rdata;

  // control state
  logic                             wide;
  logic [CW-1:0]                    count;
  logic [IW-1:0]                    prefix;
  logic [lz78be_pkg::BIT_CNT_W-1:0] bitcnt;
  logic                             pend_valid;
  logic                             out_valid;

  // payload registers
  logic [lz78be_pkg::DATA_BYTE_W-1:0] byte_reg;
  logic                               last_reg;
  logic [CW-1:0]                      code_reg;
  logic [IW-1:0]                      idx;
  logic [CW-1:0]                      pend;
  logic [CW-1:0]                      out_code;
  logic                               out_run_last;
  logic                               out_stream_end;

  // combinational helpers
  logic [CW-1:0] mask;
  logic [CW-1:0] limit;
  logic          cur_bit;
  logic [CW-1:0] code_new;
  logic [IW-1:0] scan_start;
  logic [CW-1:0] rd_masked;
  logic [CW-1:0] idx_inc;
  logic          can_store;
  logic          hit;
  logic          out_free;
  logic          out_load;
  logic          mem_we;
  logic          mem_re;
  logic [IW-1:0] raddr;

  // code forming, scan bounds and handshake helpers
  always_comb begin
    mask       = wide ? '1 : NarrowMask;
    limit      = wide ? WideLimit : NarrowLimit;
    cur_bit    = byte_reg[bitcnt];
    code_new   = {prefix, cur_bit} & mask;
    scan_start = (prefix == '0) ? IW'(1) : prefix;
    rd_masked  = rdata & mask;
    idx_inc    = {1'b0, idx} + CW'(1);
    can_store  = count < limit;
    hit        = rd_masked == code_reg;
    out_free   = !out_valid || code_ready;
    out_load   = (cmd.miss_take || cmd.flush_take || cmd.finish) && pend_valid;
    mem_we     = cmd.miss_take && can_store;
    mem_re     = cmd.scan_rd || cmd.flush_rd;
    raddr      = cmd.flush_rd ? prefix : idx;
  end

  // status toward the controller
  always_comb begin
    status.scan_empty = {1'b0, scan_start} >= count;
    status.hit        = hit;
    status.scan_end   = idx_inc >= count;
    status.can_emit   = !pend_valid || out_free;
    status.bit_last   = bitcnt == '1;
    status.last_flag  = last_reg;
    status.prefix_nz  = prefix != '0;
    status.pend_valid = pend_valid;
  end

  // dictionary write and registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count[IW-1:0]] <= code_reg;
    end
    if (mem_re) begin
      rdata <= mem[raddr];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      wide       <= 1'b1;
      count      <= CW'(1);
      prefix     <= '0;
      bitcnt     <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        wide <= cfg_wide;
      end
      if (cmd.load) begin
        bitcnt <= '0;
      end
      if (cmd.scan_cmp && hit) begin
        prefix <= idx;
        bitcnt <= bitcnt + 1'b1;
      end
      if (cmd.miss_take) begin
        if (can_store) begin
          count <= count + CW'(1);
        end
        prefix     <= '0;
        bitcnt     <= bitcnt + 1'b1;
        pend_valid <= 1'b1;
      end
      if (cmd.flush_take) begin
        pend_valid <= 1'b1;
      end
      if (cmd.finish) begin
        pend_valid <= 1'b0;
        if (last_reg) begin
          count  <= CW'(1);
          prefix <= '0;
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (code_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      byte_reg <= data_byte;
      last_reg <= last_byte;
    end
    if (cmd.bit_setup) begin
      code_reg <= code_new;
      idx      <= scan_start;
    end
    if (cmd.scan_cmp && !hit) begin
      idx <= idx_inc[IW-1:0];
    end
    if (cmd.miss_take) begin
      pend <= code_reg;
    end
    if (cmd.flush_take) begin
      pend <= rd_masked;
    end
    if (out_load) begin
      out_code       <= pend;
      out_run_last   <= cmd.finish;
      out_stream_end <= cmd.finish && last_reg;
    end
  end

  // output fields
  assign code_valid  = out_valid;
  assign code_prefix = lz78be_pkg::CODE_PREFIX_W'(out_code[CW-1:1]);
  assign code_bit    = out_code[0];
  assign run_last    = out_run_last;
  assign stream_end  = out_stream_end;

  // a code only moves to the output register once the slot is free
  `ASSERT_IMPLIES(out_load_free, clk, rst, out_load, out_free)
  // the entry count stays in its legal range
  `ASSERT_NEVER(count_range, clk, rst, count == '0 || count > WideLimit)
  // a nonempty prefix always names a written entry
  `ASSERT_IMPLIES(prefix_written, clk, rst, prefix != '0, {1'b0, prefix} < count)
  // scan reads stay inside the written part of the dictionary
  `ASSERT_IMPLIES(scan_in_range, clk, rst, cmd.scan_rd, idx != '0 && {1'b0, idx} < count)

endmodule

### tb/lz78_bitwise_encoder_unit_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for lz78_bitwise_encoder_unit: byte driver, code monitor, and
// an in-bench bitwise lz78 encoder that predicts every code transfer
// depends on lz78be_pkg, the three channel interfaces and the encoder rtl
module lz78_bitwise_encoder_unit_tb;

  localparam int unsigned MAX_IDX    = 15;
  localparam int unsigned DICT_DEPTH = 1 << MAX_IDX;
  localparam int unsigned MAX_REPORT = 40;

  typedef struct packed {
    logic [lz78be_pkg::DATA_BYTE_W-1:0] data;
    logic                               last;
  } byte_item_t;

  typedef struct packed {
    logic [lz78be_pkg::CODE_PREFIX_W-1:0] prefix;
    logic                                 cbit;
    logic                                 run_last;
    logic                                 stream_end;
  } code_word_t;

  typedef enum {FLAV_RANDOM, FLAV_SKEWED, FLAV_REPEAT} stream_flavor_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // driven copies of the block inputs, known from time zero
  logic       in_vld  = 1'b0;
  byte_item_t in_item = '0;
  logic       out_rdy = 1'b0;
  logic       cfg_vld = 1'b0;
  logic       cfg_val = 1'b0;

  // handshake flags sampled at the rising edge
  logic byte_taken = 1'b0;
  logic cfg_taken  = 1'b0;

  // idling control
  logic        quiet     = 1'b0;
  logic        hold_long = 1'b0;
  int unsigned gap_left   = 0;
  int unsigned stall_left = 0;

  // encoder state mirrored by the predictor
  logic [15:0]                        dict_mem [DICT_DEPTH];
  int unsigned                        n_entries = 1;
  logic [lz78be_pkg::CODE_PREFIX_W-1:0] cur_prefix = '0;
  logic                               wide_sel = 1'b1;

  byte_item_t byte_backlog [$];
  code_word_t pending_codes [$];

  logic [7:0] byte_palette [8] = '{8'h00, 8'hFF, 8'h0F, 8'hF0, 8'h55, 8'hAA, 8'h01, 8'h80};

  // run statistics
  int unsigned mismatches     = 0;
  int unsigned bytes_taken    = 0;
  int unsigned codes_seen     = 0;
  int unsigned streams_closed = 0;
  int unsigned flush_codes    = 0;
  int unsigned full_misses    = 0;
  int unsigned silent_bytes   = 0;
  int unsigned width_writes   = 0;
  int unsigned peak_entries   = 1;

  lz78be_byte_if byte_bus ();
  lz78be_code_if code_bus ();
  lz78be_cfg_if  cfg_bus ();

  assign byte_bus.valid     = in_vld;
  assign byte_bus.data_byte = in_item.data;
  assign byte_bus.last_byte = in_item.last;
  assign code_bus.ready     = out_rdy;
  assign cfg_bus.valid      = cfg_vld;
  assign cfg_bus.wide_codes = cfg_val;

  lz78_bitwise_encoder_unit #(
    .MAX_INDEX_BITS(MAX_IDX)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .byte_in  (byte_bus),
    .code_out (code_bus),
    .cfg      (cfg_bus)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORT) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
  endtask

  // bitwise lz78 encoding of one byte, lsb first; queues the codes it emits
  function automatic void encode_byte(input logic [7:0] data, input logic last);
    logic [15:0]  cmask;
    logic [15:0]  code;
    int unsigned  cap;
    int unsigned  idx;
    logic         found;
    code_word_t   step_codes [$];
    code_word_t   cw;
    cmask = wide_sel ? 16'hFFFF : 16'h00FF;
    cap   = wide_sel ? DICT_DEPTH : (1 << lz78be_pkg::NARROW_INDEX_BITS);
    for (int b = 0; b < 8; b++) begin
      code  = ({cur_prefix, 1'b0} | {15'd0, data[b]}) & cmask;
      idx   = (cur_prefix != 0) ? int'(cur_prefix) : 1;
      found = 1'b0;
      // linear walk from the prefix up to the entry count
      while (!found && idx < n_entries) begin
        if ((dict_mem[idx] & cmask) == code) begin
          found = 1'b1;
        end else begin
          idx++;
        end
      end
      if (found) begin
        cur_prefix = idx[lz78be_pkg::CODE_PREFIX_W-1:0];
      end else begin
        if (n_entries < cap && n_entries < DICT_DEPTH) begin
          dict_mem[n_entries] = code;
          n_entries++;
          if (n_entries > peak_entries) peak_entries = n_entries;
        end else begin
          full_misses++;
        end
        cw = '{prefix: code[15:1], cbit: code[0], run_last: 1'b0, stream_end: 1'b0};
        step_codes.push_back(cw);
        cur_prefix = '0;
      end
    end
    // end of stream: flush the pair last matched, then restart
    if (last) begin
      if (cur_prefix != 0) begin
        code = dict_mem[cur_prefix] & cmask;
        cw = '{prefix: code[15:1], cbit: code[0], run_last: 1'b0, stream_end: 1'b0};
        step_codes.push_back(cw);
        flush_codes++;
      end
      n_entries  = 1;
      cur_prefix = '0;
      streams_closed++;
    end
    if (step_codes.size() > 0) begin
      step_codes[$].run_last = 1'b1;
      if (last) step_codes[$].stream_end = 1'b1;
    end else begin
      silent_bytes++;
    end
    foreach (step_codes[i]) pending_codes.push_back(step_codes[i]);
  endfunction

  // byte driver: one item in flight, random gaps between transfers
  always @(negedge clk) begin : drive_bytes
    logic       nxt_vld;
    byte_item_t nxt_item;
    nxt_vld  = in_vld;
    nxt_item = in_item;
    if (rst) begin
      nxt_vld = 1'b0;
    end else if (!in_vld || byte_taken) begin
      nxt_vld = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (byte_backlog.size() > 0) begin
        if (!quiet && $urandom_range(0, 3) == 0) begin
          gap_left = $urandom_range(1, 9) - 1;
        end else begin
          nxt_item = byte_backlog.pop_front();
          nxt_vld  = 1'b1;
        end
      end
    end
    in_vld  <= nxt_vld;
    in_item <= nxt_item;
  end

  // code receiver: random stall bursts, plus the long hold-off
  always @(negedge clk) begin : drive_ready
    logic nxt_rdy;
    nxt_rdy = 1'b1;
    if (hold_long) begin
      nxt_rdy = 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      nxt_rdy = 1'b0;
    end else if (!quiet && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(1, 9) - 1;
      nxt_rdy    = 1'b0;
    end
    out_rdy <= nxt_rdy;
  end

  // monitor: predict on each accepted byte, check each accepted code
  always @(posedge clk) begin : observe
    code_word_t got;
    code_word_t want;
    if (rst) begin
      byte_taken = 1'b0;
      cfg_taken  = 1'b0;
    end else begin
      byte_taken = in_vld && (byte_bus.ready === 1'b1);
      cfg_taken  = cfg_vld && (cfg_bus.ready === 1'b1);
      if (cfg_taken) begin
        wide_sel = cfg_val;
        width_writes++;
      end
      if (byte_taken) begin
        encode_byte(in_item.data, in_item.last);
        bytes_taken++;
      end
      if (code_bus.valid === 1'b1 && out_rdy) begin
        got = '{prefix: code_bus.code_prefix, cbit: code_bus.code_bit,
                run_last: code_bus.run_last, stream_end: code_bus.stream_end};
        codes_seen++;
        if (pending_codes.size() == 0) begin
          report_mismatch($sformatf("code %0d unexpected: prefix %0d bit %0b",
                                    codes_seen, got.prefix, got.cbit));
        end else begin
          want = pending_codes.pop_front();
          if (got.prefix !== want.prefix)
            report_mismatch($sformatf("code %0d: code_prefix %0d, expected %0d",
                                      codes_seen, got.prefix, want.prefix));
          if (got.cbit !== want.cbit)
            report_mismatch($sformatf("code %0d: code_bit %0b, expected %0b",
                                      codes_seen, got.cbit, want.cbit));
          if (got.run_last !== want.run_last)
            report_mismatch($sformatf("code %0d: run_last %0b, expected %0b",
                                      codes_seen, got.run_last, want.run_last));
          if (got.stream_end !== want.stream_end)
            report_mismatch($sformatf("code %0d: stream_end %0b, expected %0b",
                                      codes_seen, got.stream_end, want.stream_end));
        end
      end
    end
  end

  // wait for an empty pipe, then for the worst scan of the current dictionary
  task automatic settle_block();
    while (byte_backlog.size() != 0 || in_vld || pending_codes.size() != 0) @(negedge clk);
    repeat (20 * n_entries + 64) @(negedge clk);
  endtask

  task automatic write_width(input logic wide);
    cfg_vld <= 1'b1;
    cfg_val <= wide;
    do @(negedge clk); while (!cfg_taken);
    cfg_vld <= 1'b0;
  endtask

  // idle the block, set the code width, and leave at a rising edge for queue fills
  task automatic begin_phase(input logic wide);
    settle_block();
    write_width(wide);
    @(posedge clk);
  endtask

  task automatic queue_byte(input logic [7:0] data, input logic last);
    byte_backlog.push_back('{data: data, last: last});
  endtask

  task automatic queue_stream(input int unsigned nbytes, input stream_flavor_t flav,
                              input logic close);
    byte_item_t  it;
    logic [7:0]  fill;
    fill = 8'($urandom_range(0, 255));
    for (int unsigned k = 0; k < nbytes; k++) begin
      case (flav)
        FLAV_RANDOM: it.data = 8'($urandom_range(0, 255));
        FLAV_SKEWED: it.data = byte_palette[$urandom_range(0, 7)];
        default:     it.data = fill;
      endcase
      it.last = close && (k == nbytes - 1);
      byte_backlog.push_back(it);
    end
  endtask

  // closed streams of random length and mixed content
  task automatic queue_random_streams(input int unsigned total, input int unsigned max_len);
    int unsigned    left;
    int unsigned    len;
    stream_flavor_t flav;
    left = total;
    while (left > 0) begin
      len = $urandom_range(1, max_len);
      if (len > left) len = left;
      case ($urandom_range(0, 9))
        0, 1: begin
          flav = FLAV_SKEWED;
        end
        2: begin
          flav = FLAV_REPEAT;
        end
        default: begin
          flav = FLAV_RANDOM;
        end
      endcase
      queue_stream(len, flav, 1'b1);
      left -= len;
    end
  endtask

  // long receiver hold-off while bytes keep coming
  initial begin : long_hold
    while (bytes_taken < 40) @(negedge clk);
    hold_long <= 1'b1;
    repeat (400) @(negedge clk);
    hold_long <= 1'b0;
  end

  initial begin : watchdog
    #40_000_000;
    $display("timeout: encoder stopped making progress");
    $display("** lz78_bitwise_encoder_unit: FAILED **");
    $finish;
  end

  initial begin : run
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: extreme bytes, single-byte streams, bytes that emit no code
    begin_phase(1'b1);
    queue_byte(8'h00, 1'b1);
    queue_byte(8'hFF, 1'b1);
    queue_byte(8'h55, 1'b1);
    queue_byte(8'hAA, 1'b1);
    repeat (9) queue_byte(8'h00, 1'b0);
    queue_byte(8'h00, 1'b1);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h0F, 1'b0);
    queue_byte(8'hF0, 1'b0);
    queue_byte(8'h80, 1'b0);
    queue_byte(8'h01, 1'b1);

    // wide codes, short streams
    begin_phase(1'b1);
    queue_random_streams(70, 24);

    // narrow codes: one long stream to fill the dictionary, then short ones
    begin_phase(1'b0);
    queue_stream(80, FLAV_RANDOM, 1'b1);
    queue_random_streams(30, 12);

    // wide stream left open past the narrow limit, then narrowed mid-stream
    begin_phase(1'b1);
    queue_stream(150, FLAV_RANDOM, 1'b0);
    begin_phase(1'b0);
    queue_stream(30, FLAV_RANDOM, 1'b1);

    // final stretch, no idling on either side
    settle_block();
    write_width(1'b1);
    quiet <= 1'b1;
    @(posedge clk);
    queue_random_streams(40, 16);

    settle_block();
    if (pending_codes.size() != 0)
      report_mismatch($sformatf("%0d expected codes never arrived", pending_codes.size()));

    $display("run: %0d bytes in %0d streams, %0d codes, %0d flushes, %0d silent bytes",
             bytes_taken, streams_closed, codes_seen, flush_codes, silent_bytes);
    $display("run: %0d width writes, peak %0d entries, %0d misses on a full dictionary, %0d mismatches",
             width_writes, peak_entries, full_misses, mismatches);
    if (mismatches == 0) begin
      $display("** lz78_bitwise_encoder_unit: PASSED **");
    end else begin
      $display("** lz78_bitwise_encoder_unit: FAILED **");
    end
    $finish;
  end

endmodule
